// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the gcd unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define EGCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define EGCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EGCD_ASSERT(lbl, prop, msg)
`define EGCD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/egcd_pkg.sv -----
// Shared types for the gcd unit: controller states and control/status bundles.
package egcd_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic swap;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic in_ok;
        logic cnt_done;
        logic rem_zero;
    } t_dp_stat;

endpackage

// ----- rtl/egcd_dpath.sv -----
// Datapath of the gcd unit: operand registers and a bit-serial remainder unit.
`include "assert_macros.svh"
module egcd_dpath
    import egcd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [DATA_WIDTH-1:0] i_num_a,
    input  logic [DATA_WIDTH-1:0] i_num_b,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic [DATA_WIDTH-2:0] o_gcd_value
);

    localparam int MAG_W = DATA_WIDTH - 1;
    localparam int CNT_W = $clog2(MAG_W);

    logic [MAG_W-1:0] r_big, n_big;
    logic [MAG_W-1:0] r_small, n_small;
    logic [MAG_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_inv, n_inv;
    logic [MAG_W-1:0] r_gcd, n_gcd;

    logic [MAG_W-1:0] w_a_mag, w_b_mag;
    logic             w_a_ok, w_b_ok;
    logic [MAG_W:0]   w_trial, w_diff;
    logic             w_ge;

    assign w_a_mag = i_num_a[MAG_W-1:0];
    assign w_b_mag = i_num_b[MAG_W-1:0];
    assign w_a_ok  = !i_num_a[DATA_WIDTH-1] && (w_a_mag != '0);
    assign w_b_ok  = !i_num_b[DATA_WIDTH-1] && (w_b_mag != '0);

    // one restoring step: shift next dividend bit into the partial remainder
    assign w_trial = {r_rem, r_big[MAG_W-1]};
    assign w_diff  = w_trial - {1'b0, r_small};
    assign w_ge    = (w_trial >= {1'b0, r_small});

    always_comb begin
        n_big   = r_big;
        n_small = r_small;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_inv   = r_inv;
        n_gcd   = r_gcd;
        if (i_cmd.load) begin
            n_inv = !(w_a_ok && w_b_ok);
            if (w_a_mag > w_b_mag) begin
                n_big   = w_a_mag;
                n_small = w_b_mag;
            end else begin
                n_big   = w_b_mag;
                n_small = w_a_mag;
            end
            n_rem = '0;
            n_cnt = '0;
        end else if (i_cmd.step) begin
            n_rem = w_ge ? w_diff[MAG_W-1:0] : w_trial[MAG_W-1:0];
            n_big = {r_big[MAG_W-2:0], 1'b0};
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_cmd.swap) begin
            n_big   = r_small;
            n_small = r_rem;
            n_rem   = '0;
            n_cnt   = '0;
        end
        if (i_cmd.out_load) begin
            n_gcd = r_inv ? '0 : r_small;
        end
    end

    always_ff @(posedge i_clk) begin
        r_big   <= n_big;
        r_small <= n_small;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        r_inv   <= n_inv;
        r_gcd   <= n_gcd;
    end

    assign o_stat.in_ok    = w_a_ok && w_b_ok;
    assign o_stat.cnt_done = (r_cnt == CNT_W'(MAG_W - 1));
    assign o_stat.rem_zero = (r_rem == '0);
    assign o_gcd_value     = r_gcd;

    `EGCD_ASSERT_NEXT(a_rem_below_div, i_cmd.step && o_stat.cnt_done, r_rem < r_small,
        "remainder not below divisor after last step")
    `EGCD_ASSERT_NEXT(a_swap_nonzero, i_cmd.swap, r_small != '0,
        "zero divisor loaded on swap")

endmodule

// ----- rtl/egcd_ctrl.sv -----
// Controller of the gcd unit: sequences load, remainder steps, swaps and output.
`include "assert_macros.svh"
module egcd_ctrl
    import egcd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.in_ok ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV: begin
                if (i_stat.cnt_done) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = i_stat.rem_zero ? ST_DONE : ST_DIV;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
            end
            ST_CHECK: begin
                o_cmd.swap = !i_stat.rem_zero;
            end
            ST_DONE: begin
                o_cmd.out_load = w_out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `EGCD_ASSERT(a_no_overwrite, !o_cmd.out_load || !r_out_valid || i_out_ready,
        "output register overwritten while beat pending")
    `EGCD_ASSERT_NEXT(a_invalid_skips_div,
        r_state == ST_IDLE && i_in_valid && !i_stat.in_ok, r_state == ST_DONE,
        "invalid operands entered the divide loop")

endmodule

// ----- rtl/euclid_gcd_unit.sv -----
// Top level of the gcd unit: stream ports, controller and datapath.
//
// Takes two signed operands per input beat and returns their greatest common
// divisor by repeated remainders. A zero or negative operand gives 0 with the
// invalid flag in tuser. One item is worked on at a time; each remainder is
// formed bit by bit in the bit-serial remainder unit and is followed by a check
// and swap step, with k remainder steps per item (k up to 44 for 32-bit
// operands). Invalid operands skip the remainder loop. The output register lets
// a finished result wait while the next beat is accepted and processed.
`include "assert_macros.svh"
module euclid_gcd_unit
    import egcd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // num_a, num_b
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // gcd_value
    output logic [((DATA_WIDTH-1+7)/8)*8-1:0]      m_axis_tdata,
    // invalid
    output logic                                   m_axis_tuser
);

    localparam int OUT_TDATA_W = ((DATA_WIDTH - 1 + 7) / 8) * 8;

    t_dp_cmd               w_cmd;
    t_dp_stat              w_stat;
    logic [DATA_WIDTH-2:0] w_gcd;

    egcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    egcd_dpath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_num_a     (s_axis_tdata[DATA_WIDTH-1:0]),
        .i_num_b     (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_gcd_value (w_gcd)
    );

    // result is zero exactly when the operands were rejected
    assign m_axis_tdata = OUT_TDATA_W'(w_gcd);
    assign m_axis_tuser = (w_gcd == '0);

    `EGCD_ASSERT(a_busy_no_ready, !(m_axis_tvalid && !m_axis_tready && w_cmd.out_load),
        "result loaded over a stalled beat")

endmodule
